FILE: rtl/epf_pkg.sv
`default_nettype none

package epf_pkg;

  // Source geometry
  localparam int WIDE_SIDE   = 800;
  localparam int NARROW_SIDE = 480;

  // Panel defaults
  localparam int PANEL_WIDTH_DEF  = 800;
  localparam int PANEL_HEIGHT_DEF = 480;

  // Packed framebuffer: two pixels per byte
  localparam int STORE_BYTES = 192000;
  localparam int ADDR_W      = 18;
  localparam int SUM_W       = 21;

  // Nibble masks
  localparam logic [7:0] HI_MASK = 8'hF0;
  localparam logic [7:0] LO_MASK = 8'h0F;

  // Color codes
  localparam logic [3:0] CODE_BLACK  = 4'd0;
  localparam logic [3:0] CODE_WHITE  = 4'd1;
  localparam logic [3:0] CODE_YELLOW = 4'd2;
  localparam logic [3:0] CODE_RED    = 4'd3;
  localparam logic [3:0] CODE_BLUE   = 4'd5;
  localparam logic [3:0] CODE_GREEN  = 4'd6;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Configuration register indexes
  localparam int         CFG_IDX_W    = 1;
  localparam logic [0:0] REG_PORTRAIT = 1'b0;
  localparam logic [0:0] REG_ROTATE   = 1'b1;

  // One item on its way into the read-modify-write stage
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;    // byte is inside the frame and gets written
    logic              tx0;   // odd panel x: low nibble
    logic [3:0]        code;
    logic              done;
  } epf_item_t;

  function automatic logic [3:0] colour_code(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [3:0] code;
    code = CODE_WHITE;
    if (r == 8'd0 && g == 8'd0 && b == 8'd0) begin
      code = CODE_BLACK;
    end else if (r == CHAN_MAX && g == CHAN_MAX && b == CHAN_MAX) begin
      code = CODE_WHITE;
    end else if (r == CHAN_MAX && g == CHAN_MAX && b == 8'd0) begin
      code = CODE_YELLOW;
    end else if (r == CHAN_MAX && g == 8'd0 && b == 8'd0) begin
      code = CODE_RED;
    end else if (r == 8'd0 && g == 8'd0 && b == CHAN_MAX) begin
      code = CODE_BLUE;
    end else if (r == 8'd0 && g == CHAN_MAX && b == 8'd0) begin
      code = CODE_GREEN;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/epf_ram.sv
`default_nettype none

module epf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/epf_map.sv
`default_nettype none

module epf_map
  import epf_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      portrait,
  input  wire logic      rotate,
  input  wire logic      hold,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire logic [7:0] blue,
  input  wire logic [7:0] green,
  input  wire logic [7:0] red,
  input  wire logic      image_start,
  output      logic      b_valid,
  output      epf_item_t b_item,
  input  wire logic      b_take
);

  localparam logic [10:0] PW          = 11'(PANEL_WIDTH);
  localparam logic [10:0] PH          = 11'(PANEL_HEIGHT);
  localparam logic [9:0]  STRIDE_PORT = 10'(PANEL_WIDTH / 2);
  localparam logic [9:0]  STRIDE_LAND = 10'(WIDE_SIDE / 2);
  localparam logic [9:0]  WIDE        = 10'(WIDE_SIDE);
  localparam logic [9:0]  NARROW      = 10'(NARROW_SIDE);

  logic [9:0] src_w, src_h;
  assign src_w = portrait ? NARROW : WIDE;
  assign src_h = portrait ? WIDE : NARROW;

  // Stage valids and frees
  logic v_a, v_p;
  logic a_free, p_free, b_free;
  logic accept;

  assign b_free   = !b_valid || b_take;
  assign p_free   = !v_p || b_free;
  assign a_free   = !v_a || p_free;
  assign in_ready = a_free && !hold;
  assign accept   = in_valid && in_ready;

  // Position counters
  logic [9:0]  column_count, row_count;
  logic [9:0]  column_count_next, row_count_next;
  logic [9:0]  x, y;
  logic [10:0] col_inc, row_inc;
  logic        done_now;

  always_comb begin
    x = image_start ? 10'd0 : column_count;
    y = image_start ? 10'd0 : row_count;
    col_inc = {1'b0, x} + 11'd1;
    row_inc = {1'b0, y} + 11'd1;
    done_now = 1'b0;
    column_count_next = col_inc[9:0];
    row_count_next = y;
    if (col_inc >= {1'b0, src_w}) begin
      column_count_next = 10'd0;
      if (row_inc >= {1'b0, src_h}) begin
        done_now = 1'b1;
        row_count_next = 10'd0;
      end else begin
        row_count_next = row_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 10'd0;
      row_count <= 10'd0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

  // Stage A: source position and color
  logic [9:0] a_x, a_y;
  logic [3:0] a_code;
  logic       a_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (a_free) begin
      v_a <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x <= x;
      a_y <= y;
      a_code <= colour_code(red, green, blue);
      a_done <= done_now;
    end
  end

  // Stage P: panel coordinate and row offset
  logic [9:0] tx, ty, stride;
  logic       ok_a;

  always_comb begin
    ok_a = (a_x < src_w) && (a_y < src_h);
    if (portrait) begin
      // quarter turn: source rows become panel columns
      ok_a = ok_a && ({1'b0, a_y} < PW) && ({1'b0, a_x} < PH);
      tx = rotate ? 10'(PW - 11'd1 - {1'b0, a_y}) : a_y;
      ty = rotate ? 10'(PH - 11'd1 - {1'b0, a_x}) : a_x;
      stride = STRIDE_PORT;
    end else begin
      // BMP rows are bottom-up, so the plain case flips y
      tx = rotate ? (WIDE - 10'd1 - a_x) : a_x;
      ty = rotate ? a_y : (NARROW - 10'd1 - a_y);
      stride = STRIDE_LAND;
    end
  end

  logic [8:0]  p_half;
  logic [19:0] p_prod;
  logic        p_tx0, p_ok, p_done;
  logic [3:0]  p_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else if (p_free) begin
      v_p <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && v_a) begin
      p_half <= tx[9:1];
      p_tx0 <= tx[0];
      p_prod <= {10'd0, ty} * {10'd0, stride};
      p_ok <= ok_a;
      p_code <= a_code;
      p_done <= a_done;
    end
  end

  // Stage B: byte address, bounds check
  logic [SUM_W-1:0] sum;
  logic             ok_p;

  assign sum  = SUM_W'(p_half) + SUM_W'(p_prod);
  assign ok_p = p_ok && (sum < SUM_W'(STORE_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= v_p;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && v_p) begin
      b_item.addr <= ok_p ? sum[ADDR_W-1:0] : '0;
      b_item.ok <= ok_p;
      b_item.tx0 <= p_tx0;
      b_item.code <= p_code;
      b_item.done <= p_done;
    end
  end

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_item.ok) |-> (b_item.addr < ADDR_W'(STORE_BYTES)))
    else $error("write address beyond framebuffer");

  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_take) |=> (b_valid && $stable(b_item)))
    else $error("stage B item changed while waiting");

endmodule

`default_nettype wire

FILE: rtl/epf_rmw.sv
`default_nettype none

module epf_rmw
  import epf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  output      logic              busy,
  input  wire logic              b_valid,
  input  wire epf_item_t         b_item,
  output      logic              b_take,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [ADDR_W-1:0] byte_address,
  output      logic [7:0]        byte_value,
  output      logic              image_done
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // Clearing pass after reset
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        busy <= 1'b0;
      end
    end
  end

  // Stage C: read data arrives, merge nibble, write back
  logic      v_c, o_free, c_free, c_move, c_write;
  epf_item_t c_item;
  logic      fwd;
  logic [7:0] fwd_data, rdata, old_byte, new_byte;

  assign o_free  = !out_valid || out_ready;
  assign c_free  = !v_c || o_free;
  assign b_take  = b_valid && c_free;
  assign c_move  = v_c && o_free;
  assign c_write = c_move && c_item.ok;

  assign old_byte = fwd ? fwd_data : rdata;
  assign new_byte = c_item.tx0 ? ((old_byte & HI_MASK) | {4'd0, c_item.code})
                               : ((old_byte & LO_MASK) | {c_item.code, 4'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (c_free) begin
      v_c <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      c_item <= b_item;
      // read and write of the same byte on one edge: take the new byte
      fwd <= c_write && b_item.ok && (b_item.addr == c_item.addr);
      fwd_data <= new_byte;
    end
  end

  epf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (busy || c_write),
    .waddr(busy ? clr_addr : c_item.addr),
    .wdata(busy ? 8'd0 : new_byte),
    .re   (b_take),
    .raddr(b_item.addr),
    .rdata(rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (c_move) begin
      byte_address <= c_item.ok ? c_item.addr : '0;
      byte_value <= c_item.ok ? new_byte : 8'd0;
      image_done <= c_item.done;
    end
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!out_valid && !v_c && !b_valid))
    else $error("item in flight during clearing pass");

  a_fwd_ok: assert property (@(posedge clk) disable iff (rst)
    (v_c && fwd) |-> c_item.ok)
    else $error("forwarded byte on an item that does not write");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(clr_addr) == LAST_ADDR))
    else $error("clearing pass ended early");

endmodule

`default_nettype wire

FILE: rtl/rgb_to_epaper_packed_framebuffer.sv
// RGB pixel stream to packed 4-bit six-color e-paper framebuffer.
//
// Input channel (in_valid/in_ready): one 24-bit BMP pixel per item, in file
// order (bottom row first, padding removed). image_start marks the first
// pixel of an image and restarts the column and row counters.
// Output channel (out_valid/out_ready): exactly one item per pixel, in order:
// the framebuffer byte that was written and its new value, with image_done
// on the last pixel. A pixel outside the frame writes nothing and reports
// address 0 and value 0.
// Configuration: cfg_we writes cfg_data to register cfg_index (0: portrait
// source, 1: half-turn rotation); write only while no item is in flight.
// Path: each pixel passes stages A, P, B and C, then the output register.
// Throughput: one pixel per cycle while out_ready is high; the single
// framebuffer RAM port pair does one read and one write per cycle, and
// back-to-back pixels on one byte are forwarded from the write-back stage.
// Reset: a clearing pass zeroes all 192000 framebuffer bytes, one byte per
// cycle; in_ready stays low until it ends. Config writes are taken.
// Receiver stall: the pipeline fills its empty stages, then in_ready drops.
`default_nettype none

module rgb_to_epaper_packed_framebuffer
  import epf_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [0:0]           cfg_data,
  // pixel input
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [7:0]           blue,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           red,
  input  wire logic                 image_start,
  // byte output
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [ADDR_W-1:0]    byte_address,
  output      logic [7:0]           byte_value,
  output      logic                 image_done
);

  // Config registers
  logic portrait_mode, rotate_half_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      portrait_mode <= 1'b0;
      rotate_half_turn <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PORTRAIT: portrait_mode <= cfg_data[0];
        REG_ROTATE:   rotate_half_turn <= cfg_data[0];
      endcase
    end
  end

  logic      busy;
  logic      b_valid, b_take;
  epf_item_t b_item;

  // Counters, coordinate mapping and address (3 stages)
  epf_map #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .portrait   (portrait_mode),
    .rotate     (rotate_half_turn),
    .hold       (busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .image_start(image_start),
    .b_valid    (b_valid),
    .b_item     (b_item),
    .b_take     (b_take)
  );

  // Framebuffer read-modify-write and output register
  epf_rmw u_rmw (
    .clk         (clk),
    .rst         (rst),
    .busy        (busy),
    .b_valid     (b_valid),
    .b_item      (b_item),
    .b_take      (b_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_address(byte_address),
    .byte_value  (byte_value),
    .image_done  (image_done)
  );

endmodule

`default_nettype wire
